@@ hw/rtl/bpa_pkg.sv @@
// Shared types, constants and helper functions of the buddy page allocator.
`default_nettype none
package bpa_pkg;

    localparam int ADDR_W          = 48;
    localparam int SIZE_W          = 32;
    localparam int FRAME_SHIFT     = 12;
    localparam int FRAME_BYTES     = 1 << FRAME_SHIFT;
    localparam int NUM_FRAMES_DEF  = 1024;
    localparam int ORDER_LIMIT_DEF = 6;
    localparam int RIGHT           = 1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic oom;
        logic bad;
        logic scan_init;
        logic scan_step;
        logic pick;
        logic split_step;
        logic frd;
        logic fchk_write;
        logic mrd;
        logic merge_hi;
        logic merge_lo;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic oversize;
        logic range_bad;
        logic scan_end;
        logic found_any;
        logic split_last;
        logic head_ok;
        logic merge_stop;
        logic buddy_ok;
    } sts_t;

    // Smallest order whose span holds the byte count, -1 if none up to max_ord.
    function automatic int size_order(logic [SIZE_W-1:0] size, int max_ord);
        int          res;
        logic [63:0] span;
        res = -1;
        for (int j = 15; j >= 0; j--)
        begin
            span = 64'(FRAME_BYTES) << j;
            if (j <= max_ord && span >= 64'(size))
            begin
                res = j;
            end
        end
        return res;
    endfunction

    // Order of the head placed at idx after reset, -1 if idx is not a head.
    function automatic int reset_order(int idx, int nf, int m);
        int f;
        int r;
        int rem;
        int res;
        res = -1;
        f   = (nf >> m) << m;
        if (idx < f)
        begin
            if ((idx & ((1 << m) - 1)) == 0)
            begin
                res = m;
            end
        end
        else
        begin
            r   = idx - f;
            rem = nf - f;
            for (int j = 0; j < 16; j++)
            begin
                if (j < m && rem[j] && (((rem >> (j + 1)) << (j + 1)) == r))
                begin
                    res = j;
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bpa_if.sv @@
// Request and response channel interfaces of the buddy page allocator.
`default_nettype none
interface bpa_req_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [bpa_pkg::SIZE_W-1:0]      request_bytes;
    logic [bpa_pkg::ADDR_W-1:0]      address;

    modport source (output valid, output op, output request_bytes, output address,
                    input ready);
    modport sink   (input valid, input op, input request_bytes, input address,
                    output ready);
endinterface

interface bpa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [bpa_pkg::ADDR_W-1:0]      block_address;
    logic [2:0]                      block_order;

    modport source (output valid, output status, output block_address,
                    output block_order, input ready);
    modport sink   (input valid, input status, input block_address,
                    input block_order, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bpa_ctrl.sv @@
// Sequencing state machine of the buddy page allocator.
`default_nettype none
module bpa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          out_ready,
    input  wire bpa_pkg::sts_t sts,
    output logic               in_ready,
    output logic               out_valid,
    output bpa_pkg::cmd_t      cmd
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_DISP  = 12'b0000_0000_0100,
        S_SCAN  = 12'b0000_0000_1000,
        S_DRAIN = 12'b0000_0001_0000,
        S_PICK  = 12'b0000_0010_0000,
        S_SPLIT = 12'b0000_0100_0000,
        S_FCHK  = 12'b0000_1000_0000,
        S_MREQ  = 12'b0001_0000_0000,
        S_MCHK  = 12'b0010_0000_0000,
        S_MLO   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!sts.is_free)
                begin
                    if (sts.oversize)
                    begin
                        cmd.oom    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (sts.range_bad)
                begin
                    cmd.bad    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.frd    = 1'b1;
                    state_next = S_FCHK;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (sts.found_any)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_SPLIT;
                end
                else
                begin
                    cmd.oom    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SPLIT:
            begin
                cmd.split_step = 1'b1;
                if (sts.split_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                if (sts.head_ok)
                begin
                    cmd.fchk_write = 1'b1;
                    state_next     = S_MREQ;
                end
                else
                begin
                    cmd.bad    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_MREQ:
            begin
                if (sts.merge_stop)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mrd    = 1'b1;
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (sts.buddy_ok)
                begin
                    cmd.merge_hi = 1'b1;
                    state_next   = S_MLO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MLO:
            begin
                cmd.merge_lo = 1'b1;
                state_next   = S_MREQ;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISP))
        else $error("accepted transfer not dispatched");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("response dropped while stalled");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/bpa_dp.sv @@
// Datapath of the buddy page allocator: head table memory, scan, split and merge.
`default_nettype none
module bpa_dp #(
    parameter int NUM_FRAMES  = bpa_pkg::NUM_FRAMES_DEF,
    parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
    input  wire logic                          op,
    input  wire logic [bpa_pkg::SIZE_W-1:0]    request_bytes,
    input  wire logic [bpa_pkg::ADDR_W-1:0]    address,
    input  wire bpa_pkg::cmd_t                 cmd,
    output bpa_pkg::sts_t                      sts,
    output logic [1:0]                         status,
    output logic [bpa_pkg::ADDR_W-1:0]         block_address,
    output logic [2:0]                         block_order
);

    localparam int IW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int OW  = $clog2(ORDER_LIMIT + 1);
    localparam int AW  = ((IW > ORDER_LIMIT) ? IW : ORDER_LIMIT) + 1;
    localparam int EW  = OW + 2;
    localparam int HB  = EW - 1;
    localparam int FB  = EW - 2;
    localparam int AD  = bpa_pkg::ADDR_W;

    // entry: {head, free, order}
    logic [EW-1:0]  mem [NUM_FRAMES];
    logic [EW-1:0]  rd_data_reg;

    logic [AD-1:0]  base_reg;
    logic           op_reg;
    logic [OW-1:0]  n_reg;
    logic           oversize_reg;
    logic           range_bad_reg;
    logic [IW-1:0]  idx_reg;
    logic [OW-1:0]  ord_reg;
    logic [CW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  scan_idx_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic           rd_vld_reg;
    logic [IW-1:0]  found_idx_reg [ORDER_LIMIT+1];
    logic [ORDER_LIMIT:0] found_vld_reg;
    bpa_pkg::status_t status_reg;
    logic [AD-1:0]  block_address_reg;
    logic [2:0]     block_order_reg;

    int             n_calc;
    int             clr_ord;
    logic [AD-1:0]  off;
    logic [AD-1:0]  frame_idx;
    logic [AW-1:0]  stride;
    logic [AW-1:0]  scan_nxt;
    logic [OW-1:0]  d_sel;
    logic [AW-1:0]  buddy;
    logic [AW-1:0]  upper;
    logic [IW-1:0]  lo_idx;
    logic [IW-1:0]  hi_idx;
    logic           we;
    logic [IW-1:0]  wa;
    logic [EW-1:0]  wd;
    logic           re;
    logic [IW-1:0]  ra;
    logic [OW-1:0]  ord_dn;

    assign n_calc    = bpa_pkg::size_order(request_bytes, ORDER_LIMIT);
    assign clr_ord   = bpa_pkg::reset_order(int'(clr_cnt_reg), NUM_FRAMES, ORDER_LIMIT);
    assign off       = address - base_reg;
    assign frame_idx = off >> bpa_pkg::FRAME_SHIFT;
    assign stride    = AW'(1) << n_reg;
    assign scan_nxt  = scan_idx_reg + stride;
    assign buddy     = AW'(idx_reg) ^ (AW'(1) << ord_reg);
    assign ord_dn    = ord_reg - OW'(1);
    assign upper     = AW'(idx_reg) + (AW'(1) << ord_dn);
    assign lo_idx    = (AW'(idx_reg) < buddy) ? idx_reg : buddy[IW-1:0];
    assign hi_idx    = (AW'(idx_reg) < buddy) ? buddy[IW-1:0] : idx_reg;

    always_comb
    begin
        d_sel = '0;
        for (int d = ORDER_LIMIT; d >= 0; d--)
        begin
            if (found_vld_reg[d])
            begin
                d_sel = OW'(d);
            end
        end
    end

    always_comb
    begin
        sts.clr_last   = (clr_cnt_reg == CW'(NUM_FRAMES - 1));
        sts.is_free    = (op_reg == bpa_pkg::OP_FREE);
        sts.oversize   = oversize_reg;
        sts.range_bad  = range_bad_reg;
        sts.scan_end   = (scan_nxt >= AW'(NUM_FRAMES));
        sts.found_any  = |found_vld_reg;
        sts.split_last = (ord_reg == n_reg);
        sts.head_ok    = rd_data_reg[HB] && !rd_data_reg[FB];
        sts.merge_stop = (ord_reg >= OW'(ORDER_LIMIT)) || (buddy >= AW'(NUM_FRAMES));
        sts.buddy_ok   = rd_data_reg[HB] && rd_data_reg[FB] &&
                         (rd_data_reg[OW-1:0] == ord_reg);
    end

    // memory port selection
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = '0;
        re = 1'b0;
        ra = idx_reg;
        if (cmd.clr_step)
        begin
            we = 1'b1;
            wa = clr_cnt_reg[IW-1:0];
            wd = {(clr_ord >= 0), 1'b1, OW'(clr_ord)};
        end
        else if (cmd.split_step)
        begin
            if (ord_reg > n_reg)
            begin
                we = (upper < AW'(NUM_FRAMES));
                wa = upper[IW-1:0];
                wd = {1'b1, 1'b1, ord_dn};
            end
            else
            begin
                we = 1'b1;
                wd = {1'b1, 1'b0, n_reg};
            end
        end
        else if (cmd.fchk_write)
        begin
            we = 1'b1;
            wd = {1'b1, 1'b1, rd_data_reg[OW-1:0]};
        end
        else if (cmd.merge_hi)
        begin
            we = 1'b1;
            wa = hi_idx;
            wd = {1'b0, 1'b1, ord_reg};
        end
        else if (cmd.merge_lo)
        begin
            we = 1'b1;
            wd = {1'b1, 1'b1, ord_reg};
        end
        if (cmd.scan_step)
        begin
            re = 1'b1;
            ra = scan_idx_reg[IW-1:0];
        end
        else if (cmd.frd)
        begin
            re = 1'b1;
        end
        else if (cmd.mrd)
        begin
            re = 1'b1;
            ra = buddy[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            clr_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            found_vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            rd_vld_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                found_vld_reg <= '0;
            end
            else if (rd_vld_reg && rd_data_reg[HB] && rd_data_reg[FB])
            begin
                for (int d = 0; d <= ORDER_LIMIT; d++)
                begin
                    if (rd_data_reg[OW-1:0] == OW'(d) && OW'(d) >= n_reg &&
                        !found_vld_reg[d])
                    begin
                        found_vld_reg[d] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && rd_data_reg[HB] && rd_data_reg[FB])
        begin
            for (int d = 0; d <= ORDER_LIMIT; d++)
            begin
                if (rd_data_reg[OW-1:0] == OW'(d) && !found_vld_reg[d])
                begin
                    found_idx_reg[d] <= rd_idx_reg;
                end
            end
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg   <= scan_idx_reg[IW-1:0];
            scan_idx_reg <= scan_nxt;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg <= '0;
        end
        if (cmd.load)
        begin
            op_reg            <= op;
            n_reg             <= OW'(n_calc);
            oversize_reg      <= (n_calc < 0);
            range_bad_reg     <= (address < base_reg) || (frame_idx >= AD'(NUM_FRAMES));
            idx_reg           <= frame_idx[IW-1:0];
            status_reg        <= bpa_pkg::ST_OK;
            block_address_reg <= '0;
            block_order_reg   <= '0;
        end
        if (cmd.oom)
        begin
            status_reg <= bpa_pkg::ST_OOM;
        end
        if (cmd.bad)
        begin
            status_reg <= bpa_pkg::ST_BAD;
        end
        if (cmd.pick)
        begin
            idx_reg           <= found_idx_reg[d_sel];
            ord_reg           <= d_sel;
            block_address_reg <= AD'(base_reg +
                                 (AD'(found_idx_reg[d_sel]) << bpa_pkg::FRAME_SHIFT));
            block_order_reg   <= 3'(n_reg);
        end
        if (cmd.split_step && ord_reg > n_reg)
        begin
            ord_reg <= ord_dn;
        end
        if (cmd.fchk_write)
        begin
            ord_reg         <= rd_data_reg[OW-1:0];
            block_order_reg <= 3'(rd_data_reg[OW-1:0]);
        end
        if (cmd.merge_hi)
        begin
            idx_reg <= lo_idx;
            ord_reg <= ord_reg + OW'(1);
        end
    end

    assign status        = status_reg;
    assign block_address = block_address_reg;
    assign block_order   = block_order_reg;

`ifndef ASSERT_OFF
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split_step |-> (ord_reg >= n_reg))
        else $error("split below requested order");
    a_merge_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_hi |-> (ord_reg < OW'(ORDER_LIMIT)))
        else $error("merge beyond max order");
    a_pick_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |=> (status_reg == bpa_pkg::ST_OK && block_order_reg == 3'(n_reg)))
        else $error("grant result not set");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/buddy_page_allocator_unit.sv @@
// Top level of the buddy page allocator: controller plus datapath.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | op, request_bytes, address
//  rsp     | out | valid/ready | status, block_address, block_order
//  cfg     | in  | cfg_we      | cfg_wdata (base_address)
//
// One request at a time. An allocation scans the head table memory through its
// single read port at a stride of the requested block size, then splits the
// chosen block down to the requested order. A free checks the head, then merges
// one level at a time. After reset a clearing pass writes the head table before the
// first transfer is taken. A stalled response holds and blocks new requests.
`default_nettype none
module buddy_page_allocator_unit #(
    parameter int NUM_FRAMES  = bpa_pkg::NUM_FRAMES_DEF,
    parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [bpa_pkg::ADDR_W-1:0] cfg_wdata,
    bpa_req_if.sink                         req,
    bpa_rsp_if.source                       rsp
);

    bpa_pkg::cmd_t cmd;
    bpa_pkg::sts_t sts;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    bpa_dp #(
        .NUM_FRAMES  (NUM_FRAMES),
        .ORDER_LIMIT (ORDER_LIMIT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .op            (req.op),
        .request_bytes (req.request_bytes),
        .address       (req.address),
        .cmd           (cmd),
        .sts           (sts),
        .status        (rsp.status),
        .block_address (rsp.block_address),
        .block_order   (rsp.block_order)
    );

endmodule
`default_nettype wire

@@ dv/buddy_page_allocator_unit_tb.sv @@
// Self-checking testbench of the buddy page allocator: directed and random requests.
`timescale 1ns / 100ps
module buddy_page_allocator_unit_tb;

    localparam int          NFR    = bpa_pkg::NUM_FRAMES_DEF;
    localparam int          MAXO   = bpa_pkg::ORDER_LIMIT_DEF;
    localparam int          FBYTES = bpa_pkg::FRAME_BYTES;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        bpa_pkg::status_t status;
        logic [47:0]      block_address;
        logic [2:0]       block_order;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_wdata;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // allocator model state
    int          head_ord [NFR];   // -1 when the frame is not a block head
    bit          frame_free [NFR];
    logic [47:0] base_addr;
    int          granted_frame;

    grant_t      pending_grants[$];
    int          live_frames[$];
    int          errors;
    int          snd_idle;
    int          rcv_idle;
    bit          hold_go;
    int          hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void model_reset();
        int idx;
        int o;
        for (int i = 0; i < NFR; i++)
        begin
            head_ord[i]   = -1;
            frame_free[i] = 1'b1;
        end
        idx = 0;
        while (idx < NFR)
        begin
            o = MAXO;
            while (o > 0 && (((idx & ((1 << o) - 1)) != 0) || (idx + (1 << o) > NFR)))
                o--;
            head_ord[idx] = o;
            idx += 1 << o;
        end
        base_addr = '0;
    endfunction

    function automatic void mark_span(int idx, int o, bit v);
        for (int i = 0; i < (1 << o) && idx + i < NFR; i++)
            frame_free[idx + i] = v;
    endfunction

    // Computes the grant for one request and updates the model state.
    function automatic grant_t allocate_or_free(bpa_pkg::op_t op, logic [31:0] size,
                                                logic [47:0] addr);
        grant_t      g;
        int          n;
        int          o;
        int          idx;
        int          bud;
        int          lo;
        logic [47:0] off;
        logic [47:0] fi;
        g.status        = bpa_pkg::ST_OK;
        g.block_address = '0;
        g.block_order   = '0;
        granted_frame   = -1;
        if (op == bpa_pkg::OP_ALLOC)
        begin
            n = 0;
            while (n <= MAXO && ((64'(FBYTES) << n) < 64'(size)))
                n++;
            if (n > MAXO)
            begin
                g.status = bpa_pkg::ST_OOM;
                return g;
            end
            for (int d = n; d <= MAXO; d++)
            begin
                for (int i = 0; i < NFR; i++)
                begin
                    if (head_ord[i] == d && frame_free[i])
                    begin
                        o = d;
                        mark_span(i, o, 1'b0);
                        while (o > n)
                        begin
                            o--;
                            if (i + (1 << o) < NFR)
                            begin
                                head_ord[i + (1 << o)] = o;
                                mark_span(i + (1 << o), o, 1'b1);
                            end
                        end
                        head_ord[i]     = n;
                        g.block_address = base_addr + 48'(i) * 48'(FBYTES);
                        g.block_order   = 3'(n);
                        granted_frame   = i;
                        return g;
                    end
                end
            end
            g.status = bpa_pkg::ST_OOM;
            return g;
        end
        if (addr < base_addr)
        begin
            g.status = bpa_pkg::ST_BAD;
            return g;
        end
        off = addr - base_addr;
        fi  = off >> bpa_pkg::FRAME_SHIFT;
        if (fi >= 48'(NFR))
        begin
            g.status = bpa_pkg::ST_BAD;
            return g;
        end
        idx = int'(fi);
        if (head_ord[idx] < 0 || frame_free[idx])
        begin
            g.status = bpa_pkg::ST_BAD;
            return g;
        end
        o             = head_ord[idx];
        g.block_order = 3'(o);
        mark_span(idx, o, 1'b1);
        while (o < MAXO)
        begin
            bud = idx ^ (1 << o);
            if (bud >= NFR || head_ord[bud] != o || !frame_free[bud])
                break;
            lo = (idx < bud) ? idx : bud;
            head_ord[(idx < bud) ? bud : idx] = -1;
            o++;
            head_ord[lo] = o;
            idx          = lo;
        end
        return g;
    endfunction

    // One request transfer; the prediction is made at the accepting edge.
    task automatic send_request(input bpa_pkg::op_t op, input logic [31:0] size,
                                input logic [47:0] addr);
        grant_t g;
        if ($urandom_range(99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.request_bytes <= size;
        req_ch.address       <= addr;
        do
            @(negedge clk);
        while (!req_ch.ready);
        @(posedge clk);
        g = allocate_or_free(op, size, addr);
        pending_grants.push_back(g);
        if (g.status == bpa_pkg::ST_OK && op == bpa_pkg::OP_ALLOC)
            live_frames.push_back(granted_frame);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_base(input logic [47:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_addr = v;
    endtask

    function automatic logic [47:0] frame_addr(int idx, int offs);
        return (base_addr + 48'(idx) * 48'(FBYTES) + 48'(offs)) & MASK48;
    endfunction

    // Free one live block, chosen at random, at a random offset in its head frame.
    task automatic free_live_block();
        int k;
        int idx;
        k   = $urandom_range(live_frames.size() - 1);
        idx = live_frames[k];
        live_frames.delete(k);
        send_request(bpa_pkg::OP_FREE, $urandom,
                     frame_addr(idx, $urandom_range(FBYTES - 1)));
    endtask

    task automatic test_directed();
        int f;
        send_request(bpa_pkg::OP_ALLOC, 32'd0, '0);
        send_request(bpa_pkg::OP_ALLOC, 32'd1, MASK48);
        send_request(bpa_pkg::OP_ALLOC, 32'(FBYTES), '0);
        send_request(bpa_pkg::OP_ALLOC, 32'(FBYTES + 1), '0);
        send_request(bpa_pkg::OP_ALLOC, 32'(FBYTES << MAXO), '0);
        send_request(bpa_pkg::OP_ALLOC, 32'((FBYTES << MAXO) + 1), '0);
        send_request(bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0);
        // a block of order 2, then frees inside and around it
        send_request(bpa_pkg::OP_ALLOC, 32'(3 * FBYTES), '0);
        f = live_frames[$];
        send_request(bpa_pkg::OP_FREE, '0, frame_addr(f + 1, 0));
        send_request(bpa_pkg::OP_FREE, 32'hFFFF_FFFF, frame_addr(f, 12'hABC));
        live_frames.delete(live_frames.size() - 1);
        send_request(bpa_pkg::OP_FREE, '0, frame_addr(f, 0));
        send_request(bpa_pkg::OP_FREE, '0, 48'(NFR) * 48'(FBYTES));
        send_request(bpa_pkg::OP_FREE, '0, MASK48);
        while (live_frames.size() > 0)
            free_live_block();
    endtask

    task automatic test_exhaust();
        for (int i = 0; i <= NFR >> MAXO; i++)
            send_request(bpa_pkg::OP_ALLOC, 32'(FBYTES << MAXO), '0);
        send_request(bpa_pkg::OP_ALLOC, 32'd0, '0);
        while (live_frames.size() > 0)
            free_live_block();
    endtask

    task automatic test_base_extremes();
        write_base(MASK48);
        send_request(bpa_pkg::OP_ALLOC, 32'd100, '0);
        send_request(bpa_pkg::OP_ALLOC, 32'(2 * FBYTES), '0);
        send_request(bpa_pkg::OP_FREE, '0, MASK48);
        send_request(bpa_pkg::OP_FREE, '0, 48'(FBYTES));
        // below base
        write_base(48'h8000_0000_0000);
        send_request(bpa_pkg::OP_FREE, '0, 48'h7FFF_FFFF_FFFF);
        while (live_frames.size() > 0)
            free_live_block();
    endtask

    task automatic test_random(input int count);
        int          r;
        int          o;
        logic [31:0] sz;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (live_frames.size() > 0 && (r < 35 || live_frames.size() > 40))
                free_live_block();
            else if (r < 92)
            begin
                // small orders make for long scans, so keep them rare
                o  = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(MAXO, 2);
                sz = (o == 0) ? 32'($urandom_range(FBYTES))
                              : 32'($urandom_range(FBYTES << o, (FBYTES << (o - 1)) + 1));
                send_request(bpa_pkg::OP_ALLOC, sz, 48'({$urandom, $urandom}));
            end
            else if (r < 96)
                send_request(bpa_pkg::OP_ALLOC, $urandom | 32'h0100_0000,
                             48'({$urandom, $urandom}));
            else
                send_request(bpa_pkg::OP_FREE, $urandom, 48'({$urandom, $urandom}));
        end
    endtask

    // response side: ready pattern and the long hold-off
    initial
    begin
        rsp_ch.ready <= 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go  = 1'b0;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // a transfer happens at the next rising edge when both are high here
    always @(negedge clk)
    begin
        grant_t g;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                g = pending_grants.pop_front();
                if (rsp_ch.status !== g.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_ch.status, g.status));
                if (rsp_ch.block_address !== g.block_address)
                    report_mismatch($sformatf("block_address %h, expected %h",
                                              rsp_ch.block_address, g.block_address));
                if (rsp_ch.block_order !== g.block_order)
                    report_mismatch($sformatf("block_order %0d, expected %0d",
                                              rsp_ch.block_order, g.block_order));
            end
        end
    end

    initial
    begin
        errors               = 0;
        hold_go              = 1'b0;
        snd_idle             = 0;
        rcv_idle             = 0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.op            <= bpa_pkg::OP_ALLOC;
        req_ch.request_bytes <= '0;
        req_ch.address       <= '0;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 25;
        rcv_idle = 52;
        test_directed();
        test_exhaust();
        test_random(300);
        test_base_extremes();

        snd_idle = 52;
        rcv_idle = 25;
        write_base(48'({$urandom_range(32'h7FFF), $urandom}));
        test_random(300);

        snd_idle = 0;
        rcv_idle = 0;
        write_base('0);
        hold_go = 1'b1;
        test_random(300);
        while (live_frames.size() > 0)
            free_live_block();

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
